// ===== design/fisa_pkg.sv =====
// ----------------------------------------------------------------------------
// Free index stack allocator package
// Field widths, command and status codes, and the per-word decision record
// shared by the allocator modules.
// ----------------------------------------------------------------------------
package fisa_pkg;

   localparam int IDX_W = 10;
   localparam int CNT_W = 11;
   localparam int DEPTH_DEFAULT = 1024;
   localparam logic [CNT_W-1:0] MAX_COUNT_RESET = 11'd1024;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Outcome of one request, worked out when the word is accepted.
   typedef struct packed {
      status_type             status;
      logic                   alloc_ok;
      logic                   from_ram;
      logic [IDX_W-1:0]       ident;
      logic [CNT_W-1:0]       count;
   } step_type;

endpackage

// ===== design/fisa_channels.sv =====
// ----------------------------------------------------------------------------
// Free index stack allocator channels
// Valid/ready channels for requests, responses and the limit register.
// ----------------------------------------------------------------------------
interface fisa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [fisa_pkg::IDX_W-1:0] free_index;

   modport source (output valid, output cmd, output free_index, input ready);
   modport sink   (input valid, input cmd, input free_index, output ready);
endinterface

interface fisa_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fisa_pkg::IDX_W-1:0] alloc_index;
   logic [1:0]                status;
   logic [fisa_pkg::CNT_W-1:0] in_use_count;

   modport source (output valid, output alloc_index, output status,
                   output in_use_count, input ready);
   modport sink   (input valid, input alloc_index, input status,
                   input in_use_count, output ready);
endinterface

interface fisa_csr_if;
   logic                      valid;
   logic                      ready;
   logic [fisa_pkg::CNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fisa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module fisa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/fisa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Free index stack allocator control
// Holds the limit register, the in-use count and the high-water mark, decides
// each request and drives the table RAM.
// ----------------------------------------------------------------------------
module fisa_ctrl #(
   parameter int DEPTH = fisa_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_we,
   input  logic [fisa_pkg::CNT_W-1:0]    cfg_data,
   input  logic                          accept,
   input  logic                          cmd,
   input  logic [fisa_pkg::IDX_W-1:0]    free_index,
   output fisa_pkg::step_type            step,
   output logic                          ram_wr_en,
   output logic                          ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]      ram_addr,
   output logic [fisa_pkg::IDX_W-1:0]    ram_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > fisa_pkg::CNT_W) ? CW : fisa_pkg::CNT_W;

   logic [fisa_pkg::CNT_W-1:0] max_count_ff, max_count_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              hwm_ff, hwm_in;
   logic [CW-1:0]              count_inc, count_dec, count_next;
   logic [EW-1:0]              count_ext, limit_ext, next_ext;
   logic                       limit_hit, alloc_ok, free_ok;

   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);
   assign count_ext = EW'(count_ff);
   assign limit_ext = EW'(max_count_ff);

   // The limit is the register capped at the table depth.
   assign limit_hit = (count_ext >= limit_ext) || (count_ff == CW'(DEPTH));
   assign alloc_ok  = (cmd == fisa_pkg::CMD_ALLOC) && !limit_hit;
   assign free_ok   = (cmd == fisa_pkg::CMD_FREE) && (count_ff != '0);

   always_comb begin
      count_next = count_ff;
      if (alloc_ok) begin
         count_next = count_inc;
      end else if (free_ok) begin
         count_next = count_dec;
      end
   end

   assign next_ext = EW'(count_next);

   always_comb begin
      step.alloc_ok = alloc_ok;
      step.ident    = count_ext[fisa_pkg::IDX_W-1:0];
      step.count    = next_ext[fisa_pkg::CNT_W-1:0];
      // Positions at or above the high-water mark were never written and
      // still hold their own position.
      step.from_ram = (count_ff < hwm_ff);
      if (cmd == fisa_pkg::CMD_ALLOC) begin
         step.status = alloc_ok ? fisa_pkg::ST_OK : fisa_pkg::ST_EMPTY;
      end else begin
         step.status = free_ok ? fisa_pkg::ST_OK : fisa_pkg::ST_UNDERFLOW;
      end
   end

   assign ram_rd_en = accept && alloc_ok;
   assign ram_wr_en = accept && free_ok;
   assign ram_addr  = (cmd == fisa_pkg::CMD_FREE) ? count_dec[AW-1:0] : count_ff[AW-1:0];
   assign ram_wdata = free_index;

   assign max_count_in = cfg_we ? cfg_data : max_count_ff;
   assign count_in     = accept ? count_next : count_ff;
   assign hwm_in       = (accept && alloc_ok && (count_ff == hwm_ff)) ? count_inc : hwm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= fisa_pkg::MAX_COUNT_RESET;
         count_ff     <= '0;
         hwm_ff       <= '0;
      end else begin
         max_count_ff <= max_count_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("in-use count beyond table depth");

   a_hwm_covers_count: assert property (@(posedge clock) disable iff (reset)
      hwm_ff >= count_ff)
      else $error("high-water mark below in-use count");

   a_ram_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("table read and write in one cycle");

   a_count_moves_by_one: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_inc))
                 || (count_ff == $past(count_dec)))
      else $error("in-use count moved by more than one");

endmodule

// ===== design/free_index_stack_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Free index stack allocator
// Hands out and takes back small indices from a stack of free indices kept
// in a single-port table RAM.
// ----------------------------------------------------------------------------
//
//   Port      Dir   Word contents                          Taken when
//   req_bus   in    cmd, free_index                        valid && ready
//   rsp_bus   out   alloc_index, status, in_use_count      valid && ready
//   csr_bus   in    max_count (limit on allocations)       valid && ready
//
// One request word is accepted per cycle unless the response stalls; its response
// is set by the registered read of the table RAM and the response register
// behind it.
// Reset clears the in-use count and the high-water mark; the table needs no
// clearing pass, since positions above the mark read as their own position.
// A stalled response holds in its register while one more request can still
// sit in the first stage; only then does req_bus.ready drop.
// The limit register is always ready and should be written only when idle.
//
module free_index_stack_allocator_core #(
   parameter int DEPTH = fisa_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fisa_req_if.sink   req_bus,
   fisa_rsp_if.source rsp_bus,
   fisa_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(DEPTH);

   fisa_pkg::step_type          step;
   logic                        accept;
   logic                        ram_wr_en, ram_rd_en;
   logic [AW-1:0]               ram_addr;
   logic [fisa_pkg::IDX_W-1:0]  ram_wdata, ram_rdata;

   // First stage: the decision taken at acceptance, waiting for the RAM data.
   fisa_pkg::step_type          s1_step_ff, s1_step_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_move;

   // Response register.
   logic                        s2_valid_ff, s2_valid_in;
   logic [fisa_pkg::IDX_W-1:0]  s2_index_ff, s2_index_in;
   logic [1:0]                  s2_status_ff, s2_status_in;
   logic [fisa_pkg::CNT_W-1:0]  s2_count_ff, s2_count_in;

   assign csr_bus.ready = 1'b1;

   // The first stage moves on whenever the response register is empty or is
   // being taken this cycle, so the pipeline keeps one word per cycle.
   assign s1_move       = s1_valid_ff && (!s2_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign accept        = req_bus.valid && req_bus.ready;

   fisa_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_we     (csr_bus.valid && csr_bus.ready),
      .cfg_data   (csr_bus.data),
      .accept     (accept),
      .cmd        (req_bus.cmd),
      .free_index (req_bus.free_index),
      .step       (step),
      .ram_wr_en  (ram_wr_en),
      .ram_rd_en  (ram_rd_en),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata)
   );

   // The RAM is read only on an accepted allocate, and the first stage only
   // changes on acceptance, so its read data stays matched to the stage.
   fisa_ram #(
      .WIDTH (fisa_pkg::IDX_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .wr_en (ram_wr_en),
      .rd_en (ram_rd_en),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign s1_step_in  = accept ? step : s1_step_ff;

   always_comb begin
      // A free or a failed allocate reports index zero; a fresh position is its own index.
      if (!s1_step_ff.alloc_ok) begin
         s2_index_in = '0;
      end else if (s1_step_ff.from_ram) begin
         s2_index_in = ram_rdata;
      end else begin
         s2_index_in = s1_step_ff.ident;
      end
      s2_status_in = s1_step_ff.status;
      s2_count_in  = s1_step_ff.count;
      s2_valid_in  = s1_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_step_ff <= s1_step_in;
      if (s1_move) begin
         s2_index_ff  <= s2_index_in;
         s2_status_ff <= s2_status_in;
         s2_count_ff  <= s2_count_in;
      end
   end

   assign rsp_bus.valid        = s2_valid_ff;
   assign rsp_bus.alloc_index  = s2_index_ff;
   assign rsp_bus.status       = s2_status_ff;
   assign rsp_bus.in_use_count = s2_count_ff;

   a_fail_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != fisa_pkg::ST_OK)) |-> (rsp_bus.alloc_index == '0))
      else $error("failed request reported a non-zero index");

   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.status == fisa_pkg::ST_OK
                         || rsp_bus.status == fisa_pkg::ST_EMPTY
                         || rsp_bus.status == fisa_pkg::ST_UNDERFLOW))
      else $error("response carries an undefined status");

endmodule
